// ===== rtl/swm_pkg.sv =====
package swm_pkg;

    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int CFG_WIDTH        = 7;

    localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RESET = 7'd3;

    // per-cell control, one per accepted sample
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

// ===== rtl/swm_cell.sv =====
module swm_cell #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
    parameter int KW           = 7,
    parameter int IDX          = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  swm_pkg::cell_ctrl_t            ctrl,
    input  logic [KW-1:0]                  k,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           prev_vld,
    input  logic signed [SAMPLE_WIDTH-1:0] prev_val,
    output logic                           vld,
    output logic signed [SAMPLE_WIDTH-1:0] val
);

    logic vld_reg;
    logic vld_next;
    logic signed [SAMPLE_WIDTH-1:0] val_reg;
    logic kill;

    // entry moving in has age IDX relative to the new sample
    assign kill     = ctrl.clear || (KW'(IDX) >= k) || (prev_val < sample);
    assign vld_next = prev_vld && !kill;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            val_reg <= prev_val;
        end
    end

    assign vld = vld_reg;
    assign val = val_reg;

endmodule

// ===== rtl/swm_max_node.sv =====
module swm_max_node #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           adv,
    input  logic                           a_vld,
    input  logic signed [SAMPLE_WIDTH-1:0] a_val,
    input  logic                           b_vld,
    input  logic signed [SAMPLE_WIDTH-1:0] b_val,
    output logic                           vld,
    output logic signed [SAMPLE_WIDTH-1:0] val
);

    logic                           vld_reg;
    logic                           vld_next;
    logic signed [SAMPLE_WIDTH-1:0] val_reg;
    logic signed [SAMPLE_WIDTH-1:0] val_next;

    always_comb
    begin
        vld_next = a_vld || b_vld;
        priority if (!a_vld)
        begin
            val_next = b_val;
        end
        else if (!b_vld)
        begin
            val_next = a_val;
        end
        else if (a_val >= b_val)
        begin
            val_next = a_val;
        end
        else
        begin
            val_next = b_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vld_reg <= vld_next;
            val_reg <= val_next;
        end
    end

    assign vld = vld_reg;
    assign val = val_reg;

endmodule

// ===== rtl/sliding_window_maximum_unit.sv =====
// channel  | handshake             | payload
// ---------+-----------------------+-------------------------
// in       | in_valid / in_stall   | sample, start_req
// out      | out_valid / out_stall | window_max
// cfg      | cfg_we                | cfg_wdata (window size)
//
// One sample per cycle while in_stall is low. A result is registered in the cell line
// and then at each level of the registered max tree over the cells.
// Reset clears cell valid bits, the fill count and the result flags and loads the reset window size; no sweep.
// out_stall with a result waiting freezes the whole tree and raises in_stall.
module sliding_window_maximum_unit #(
    parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]      sample,
    input  logic                                start_req,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      window_max,
    input  logic                                cfg_we,
    input  logic [swm_pkg::CFG_WIDTH-1:0]       cfg_wdata
);

    localparam int LEVELS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int NPAD   = 1 << LEVELS;
    localparam int KW     = $clog2(WINDOW_MAX + 1);
    localparam int CW     = (KW > swm_pkg::CFG_WIDTH) ? KW : swm_pkg::CFG_WIDTH;

    logic [swm_pkg::CFG_WIDTH-1:0] window_size_reg;
    logic [KW-1:0]                 fill_reg;
    logic [KW-1:0]                 fill_next;
    logic [LEVELS:0]               flag_reg;
    logic [LEVELS:0]               flag_next;

    logic [CW-1:0] ws_ext;
    logic [CW-1:0] k_wide;
    logic [KW-1:0] k;
    logic          adv;
    logic          accept;
    logic          has_result;

    logic                           cell_vld [0:WINDOW_MAX-1];
    logic signed [SAMPLE_WIDTH-1:0] cell_val [0:WINDOW_MAX-1];
    logic                           tree_vld [0:2*NPAD-2];
    logic signed [SAMPLE_WIDTH-1:0] tree_val [0:2*NPAD-2];

    assign adv      = !(flag_reg[LEVELS] && out_stall);
    assign in_stall = !adv;
    assign accept   = in_valid && adv;

    // effective window: zero acts as one, large values saturate
    always_comb
    begin
        ws_ext = CW'(window_size_reg);
        priority if (ws_ext == '0)
        begin
            k_wide = CW'(1);
        end
        else if (ws_ext > CW'(WINDOW_MAX))
        begin
            k_wide = CW'(WINDOW_MAX);
        end
        else
        begin
            k_wide = ws_ext;
        end
        k = KW'(k_wide);
    end

    always_comb
    begin
        priority if (start_req)
        begin
            fill_next = KW'(1);
        end
        else if (fill_reg == KW'(WINDOW_MAX))
        begin
            fill_next = fill_reg;
        end
        else
        begin
            fill_next = fill_reg + KW'(1);
        end
        has_result = (fill_next >= k);
        flag_next  = {flag_reg[LEVELS-1:0], accept && has_result};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= swm_pkg::WINDOW_SIZE_RESET;
            fill_reg        <= '0;
            flag_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_size_reg <= cfg_wdata;
            end
            if (accept)
            begin
                fill_reg <= fill_next;
            end
            if (adv)
            begin
                flag_reg <= flag_next;
            end
        end
    end

    // shift line of candidates, cell 0 holds the newest sample
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++)
        begin : g_cell
            swm_pkg::cell_ctrl_t            ctrl;
            logic                           p_vld;
            logic signed [SAMPLE_WIDTH-1:0] p_val;

            if (gi == 0)
            begin : g_head
                assign ctrl  = '{shift: accept, clear: 1'b0};
                assign p_vld = 1'b1;
                assign p_val = sample;
            end
            else
            begin : g_body
                assign ctrl  = '{shift: accept, clear: start_req};
                assign p_vld = cell_vld[gi-1];
                assign p_val = cell_val[gi-1];
            end

            swm_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .KW           (KW),
                .IDX          (gi)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .k        (k),
                .sample   (sample),
                .prev_vld (p_vld),
                .prev_val (p_val),
                .vld      (cell_vld[gi]),
                .val      (cell_val[gi])
            );
        end

        // heap-ordered tree leaves
        for (gi = 0; gi < NPAD; gi++)
        begin : g_leaf
            if (gi < WINDOW_MAX)
            begin : g_used
                assign tree_vld[NPAD-1+gi] = cell_vld[gi];
                assign tree_val[NPAD-1+gi] = cell_val[gi];
            end
            else
            begin : g_pad
                assign tree_vld[NPAD-1+gi] = 1'b0;
                assign tree_val[NPAD-1+gi] = '0;
            end
        end

        for (gi = 0; gi < NPAD-1; gi++)
        begin : g_node
            swm_max_node #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH)
            ) u_node (
                .clk   (clk),
                .adv   (adv),
                .a_vld (tree_vld[2*gi+1]),
                .a_val (tree_val[2*gi+1]),
                .b_vld (tree_vld[2*gi+2]),
                .b_val (tree_val[2*gi+2]),
                .vld   (tree_vld[gi]),
                .val   (tree_val[gi])
            );
        end
    endgenerate

    assign out_valid  = flag_reg[LEVELS] && tree_vld[0];
    assign window_max = tree_val[0];

endmodule

// ===== rtl/swm_checker.sv =====
module swm_checker #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic signed [SAMPLE_WIDTH-1:0] window_max
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(window_max))
        else $error("stalled result changed");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while tree is frozen");

    a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with no result waiting");

endmodule

bind sliding_window_maximum_unit swm_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .window_max (window_max)
);

// ===== dv/tb_sliding_window_maximum_unit.sv =====
`timescale 1ns / 100ps

localparam int PTR_W = $clog2(swm_pkg::WINDOW_MAX_DEF);
localparam int POS_W = PTR_W + 1;

// Tracks the candidate deque of the running window and queues the expected maxima.
class running_max_tracker;
    logic signed [swm_pkg::SAMPLE_WIDTH_DEF-1:0] cand_val [swm_pkg::WINDOW_MAX_DEF];
    logic [POS_W-1:0]                   cand_pos [swm_pkg::WINDOW_MAX_DEF];
    logic [PTR_W-1:0]                   head_idx;
    logic [PTR_W-1:0]                   tail_idx;
    logic [POS_W-1:0]                   next_pos;
    logic [swm_pkg::CFG_WIDTH-1:0]      window_reg;
    int                                 occupied;
    int                                 filled;
    logic signed [swm_pkg::SAMPLE_WIDTH_DEF-1:0] expected_max [$];
    int                                 mismatches;
    int                                 maxima_checked;
    int                                 samples_taken;

    function new();
        head_idx       = '0;
        tail_idx       = '0;
        next_pos       = '0;
        occupied       = 0;
        filled         = 0;
        window_reg     = swm_pkg::WINDOW_SIZE_RESET;
        mismatches     = 0;
        maxima_checked = 0;
        samples_taken  = 0;
    endfunction

    function void set_window(logic [swm_pkg::CFG_WIDTH-1:0] value);
        window_reg = value;
    endfunction

    function void take_sample(logic signed [swm_pkg::SAMPLE_WIDTH_DEF-1:0] value,
                              logic restart);
        int               k;
        logic [POS_W-1:0] age;
        logic [PTR_W-1:0] back;
        logic             done;
        if (window_reg == 0)
            k = 1;
        else if (window_reg > swm_pkg::WINDOW_MAX_DEF)
            k = swm_pkg::WINDOW_MAX_DEF;
        else
            k = window_reg;
        samples_taken++;
        if (restart)
        begin
            head_idx = '0;
            tail_idx = '0;
            next_pos = '0;
            occupied = 0;
            filled   = 0;
        end
        // front: drop candidates that aged out (position wraps at 2*WINDOW_MAX)
        done = 1'b0;
        while (occupied > 0 && !done)
        begin
            age = next_pos - cand_pos[head_idx];
            if (age < k)
                done = 1'b1;
            else
            begin
                head_idx++;
                occupied--;
            end
        end
        // back: drop strictly smaller candidates, ties stay
        done = 1'b0;
        while (occupied > 0 && !done)
        begin
            back = tail_idx - 1'b1;
            if (cand_val[back] < value)
            begin
                tail_idx = back;
                occupied--;
            end
            else
                done = 1'b1;
        end
        if (occupied < swm_pkg::WINDOW_MAX_DEF)
        begin
            cand_val[tail_idx] = value;
            cand_pos[tail_idx] = next_pos;
            tail_idx++;
            occupied++;
        end
        next_pos++;
        if (filled < swm_pkg::WINDOW_MAX_DEF)
            filled++;
        if (filled >= k)
            expected_max = {expected_max, cand_val[head_idx]};
    endfunction

    function void check_max(logic signed [swm_pkg::SAMPLE_WIDTH_DEF-1:0] actual);
        logic signed [swm_pkg::SAMPLE_WIDTH_DEF-1:0] want;
        maxima_checked++;
        if (expected_max.size() == 0)
        begin
            $error("window_max: expected none, actual %0d", actual);
            mismatches++;
        end
        else
        begin
            want = expected_max.pop_front();
            if (want !== actual)
            begin
                $error("window_max: expected %0d, actual %0d", want, actual);
                mismatches++;
            end
        end
    endfunction

    function int pending();
        return expected_max.size();
    endfunction
endclass

module tb_sliding_window_maximum_unit;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 152;

    logic                                        clk;
    logic                                        rst_n;
    logic                                        in_valid;
    logic                                        in_stall;
    logic signed [swm_pkg::SAMPLE_WIDTH_DEF-1:0] sample;
    logic                                        start_req;
    logic                                        out_valid;
    logic                                        out_stall;
    logic signed [swm_pkg::SAMPLE_WIDTH_DEF-1:0] window_max;
    logic                                        cfg_we;
    logic [swm_pkg::CFG_WIDTH-1:0]               cfg_wdata;

    int send_idle;
    int recv_idle;
    int cycles;
    int settings_used;

    running_max_tracker tracker;

    sliding_window_maximum_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .start_req  (start_req),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .window_max (window_max),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_sliding_window_maximum_unit failed");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            tracker.check_max(window_max);

    // one input transfer; called and returns at a falling edge
    task automatic push_sample(input logic signed [swm_pkg::SAMPLE_WIDTH_DEF-1:0] value,
                               input logic restart);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        sample    <= value;
        start_req <= restart;
        do
            @(posedge clk);
        while (in_stall);
        tracker.take_sample(value, restart);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [swm_pkg::CFG_WIDTH-1:0] value);
        in_valid <= 1'b0;
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        tracker.set_window(value);
        settings_used++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [swm_pkg::SAMPLE_WIDTH_DEF-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return {1'b0, {(swm_pkg::SAMPLE_WIDTH_DEF-1){1'b1}}};
            1:       return {1'b1, {(swm_pkg::SAMPLE_WIDTH_DEF-1){1'b0}}};
            2, 3, 4: return $signed($urandom_range(7)) - 4;   // narrow range, many ties
            5:       return $urandom_range(1) ? '0 : '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random(input int phase, input int budget);
        int   sent;
        int   len;
        int   k;
        int   i;
        logic opened;
        k = (tracker.window_reg == 0) ? 1 :
            (tracker.window_reg > swm_pkg::WINDOW_MAX_DEF) ? swm_pkg::WINDOW_MAX_DEF :
            tracker.window_reg;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(9) == 0)
                len = $urandom_range(k, 1);               // cut short, at most one window long
            else
                len = $urandom_range(3 * k + 8, k);
            if (len > budget - sent)
                len = budget - sent;
            // odd phases carry the old sequence over the size change
            opened = !(sent == 0 && phase[0]);
            for (i = 0; i < len; i++)
                push_sample(pick_sample(), (i == 0 && opened) || ($urandom_range(63) == 0));
            sent += len;
        end
    endtask

    logic [swm_pkg::CFG_WIDTH-1:0] window_plan [PHASES];

    initial
    begin
        int p;
        tracker       = new();
        cycles        = 0;
        settings_used = 0;
        send_idle     = 11;
        recv_idle     = 62;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        sample        = '0;
        start_req     = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        window_plan   = '{7'd1, 7'd0, 7'd2, 7'd64, 7'd127, 7'd5, 7'd65, 7'd3,
                          7'd33, 7'd0, 7'd8, 7'd0};
        window_plan[9]  = 7'($urandom_range(swm_pkg::WINDOW_MAX_DEF, 1));
        window_plan[11] = 7'($urandom_range(swm_pkg::WINDOW_MAX_DEF, 1));
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed run at the reset window of three
        push_sample(32'sh7fff_ffff, 1'b1);
        push_sample(32'sh8000_0000, 1'b0);
        push_sample(32'sh8000_0000, 1'b0);
        push_sample(32'sd5, 1'b0);
        push_sample(32'sd5, 1'b0);
        push_sample(32'sd5, 1'b0);
        push_sample(32'sd4, 1'b0);
        push_sample(32'sd3, 1'b0);
        push_sample(32'sd2, 1'b0);
        push_sample(32'sd10, 1'b0);
        push_sample(32'sd20, 1'b0);
        push_sample(32'sd30, 1'b0);
        push_sample(-32'sd1, 1'b1);
        push_sample(-32'sd1, 1'b0);
        push_sample(-32'sd1, 1'b0);
        push_sample(32'sd0, 1'b0);
        push_sample(32'sh7fff_ffff, 1'b1);
        push_sample(32'sh7fff_ffff, 1'b0);
        push_sample(32'sh7fff_ffff, 1'b0);
        push_sample(32'sh8000_0000, 1'b0);
        push_sample(32'sh8000_0000, 1'b0);
        push_sample(32'sh8000_0000, 1'b0);

        for (p = 0; p < PHASES; p++)
        begin
            write_window(window_plan[p]);
            if (p == 4)
            begin
                send_idle = 62;
                recv_idle = 11;
            end
            else if (p == 8)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            run_random(p, PHASE_ITEMS);
        end

        in_valid <= 1'b0;
        wait_drained();
        $display("%0d samples over %0d window settings, %0d window maxima checked",
                 tracker.samples_taken, settings_used, tracker.maxima_checked);
        $display("sizes covered: zero, one, full depth and above, changes mid-sequence");
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("tb_sliding_window_maximum_unit passed");
        else
            $display("tb_sliding_window_maximum_unit failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/swm_max_node.sv
rtl/sliding_window_maximum_unit.sv
rtl/swm_checker.sv
dv/tb_sliding_window_maximum_unit.sv
